// ===== src/rbst_pkg.sv =====
// ----------------------------------------------------------------------------
// Rating bias trainer package
// Shared widths, table sizes, op codes, datapath commands and helper functions.
// ----------------------------------------------------------------------------
package rbst_pkg;

   localparam int USER_COUNT = 65536;
   localparam int ITEM_COUNT = 16384;
   localparam int FRAC_BITS  = 16;

   localparam int UAW       = $clog2(USER_COUNT);
   localparam int IAW       = $clog2(ITEM_COUNT);
   localparam int TABLE_MAX = (USER_COUNT > ITEM_COUNT) ? USER_COUNT : ITEM_COUNT;
   localparam int WALK_W    = $clog2(TABLE_MAX);

   localparam int BIAS_W  = 48;
   localparam int CNT_W   = 24;
   localparam int WORD_W  = BIAS_W + CNT_W;
   localparam int SUM_W   = BIAS_W + 2;
   localparam int DIVS_W  = CNT_W + 1;
   localparam int DIVC_W  = $clog2(BIAS_W);

   localparam int MEAN_W  = 19;
   localparam int Q_W     = 16;
   localparam int PRED_W  = 19;
   localparam int ERR_W   = 20;
   localparam int SQ_W    = 21;

   localparam int MUL_SPLIT = 24;
   localparam int MLO_W     = MUL_SPLIT + Q_W;
   localparam int MHI_W     = SUM_W - MUL_SPLIT + Q_W;
   localparam int FULL_W    = SUM_W + Q_W;

   localparam logic [CNT_W-1:0]  COUNT_MAX   = '1;
   localparam logic [DIVS_W-1:0] ITEM_SHRINK = DIVS_W'(25);
   localparam logic [DIVS_W-1:0] USER_SHRINK = DIVS_W'(10);
   localparam logic [2:0]        RATING_MIN  = 3'd1;
   localparam logic [2:0]        RATING_MAX  = 3'd5;
   localparam logic [SQ_W-1:0]   SQ_MAX      = '1;

   localparam logic signed [SUM_W-1:0] PRED_LO = SUM_W'(1) << FRAC_BITS;
   localparam logic signed [SUM_W-1:0] PRED_HI = SUM_W'(5) << FRAC_BITS;
   localparam logic signed [SUM_W-1:0] BIAS_MAX_S =
      SUM_W'({1'b0, {(BIAS_W-1){1'b1}}});
   localparam logic signed [SUM_W-1:0] BIAS_MIN_S = -BIAS_MAX_S - SUM_W'(1);

   typedef enum logic [2:0] {
      OP_ITEM_ACC = 3'd0,
      OP_ITEM_FIN = 3'd1,
      OP_USER_ACC = 3'd2,
      OP_USER_FIN = 3'd3,
      OP_TRAIN    = 3'd4
   } op_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_CLEAR,
      CMD_READ_REQ,
      CMD_READ_WALK,
      CMD_ACC,
      CMD_PRED,
      CMD_SQ,
      CMD_LOAD_REG,
      CMD_MUL_LO,
      CMD_MUL_HI,
      CMD_MUL_FIN,
      CMD_LOAD_LR,
      CMD_UPDATE,
      CMD_WRITE_TRAIN,
      CMD_WALK_CHECK,
      CMD_DIV_STEP,
      CMD_WALK_WRITE,
      CMD_RESPOND
   } dp_cmd_type;

   typedef struct packed {
      dp_cmd_type        cmd;
      logic              sel_item;   // item side for accumulate and update
      logic              walk_user;  // table under walk is the user table
      logic              train;      // response carries training results
      logic [WALK_W-1:0] walk;
   } dp_ctl_type;

   typedef struct packed {
      logic count_zero;
   } dp_stat_type;

   function automatic logic signed [BIAS_W-1:0] sat_bias(input logic signed [SUM_W-1:0] v);
      if (v > BIAS_MAX_S)      return BIAS_MAX_S[BIAS_W-1:0];
      else if (v < BIAS_MIN_S) return BIAS_MIN_S[BIAS_W-1:0];
      else                     return v[BIAS_W-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
      return (c == COUNT_MAX) ? c : c + CNT_W'(1);
   endfunction

endpackage

// ===== src/rating_bias_sgd_trainer_top.sv =====
// ----------------------------------------------------------------------------
// Rating bias SGD trainer, top level
// Baseline predictor (mean + user bias + item bias) with bias setup and training.
// ----------------------------------------------------------------------------
// Usage. A command word is taken at a rising edge where start is high and busy
// is low; its op selects item or user accumulation, item or user finalize, or
// one training step. Exactly one result word follows every command, shown for
// a single cycle with rsp_strobe high. The receiver cannot stall, so the result
// must be captured in that cycle. Prediction, error and squared error are zero
// for every command other than a training step that is carried out.
// An accumulate reads both tables and writes back the updated entry; a training
// step predicts, squares the error and, with update enable set, updates and
// writes back both biases; an unused op or one that fails its index check goes
// straight to its response. Busy drops in the cycle the result is shown, so the
// next command can be accepted then. A finalize walks the whole table, one entry
// at a time through a one-bit-per-cycle divider that empty entries skip. Reset
// is synchronous; afterwards a clearing pass writes zero to every table entry,
// one address per cycle, with busy held high. Configuration registers (mean,
// learning rate, regularization, update enable) sit at byte addresses 0, 4, 8 and
// 12. The user must write them only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module rating_bias_sgd_trainer_top import rbst_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [2:0]              req_op,
   input  logic [15:0]             req_user_index,
   input  logic [13:0]             req_item_index,
   input  logic [2:0]              req_rating,
   output logic                    rsp_strobe,
   output logic [PRED_W-1:0]       rsp_prediction,
   output logic signed [ERR_W-1:0] rsp_error,
   output logic [SQ_W-1:0]         rsp_squared_error,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [3:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   // Register indexes, taken from word address bits.
   localparam logic [1:0] REG_MEAN   = 2'd0;
   localparam logic [1:0] REG_RATE   = 2'd1;
   localparam logic [1:0] REG_REG    = 2'd2;
   localparam logic [1:0] REG_ENABLE = 2'd3;

   logic [MEAN_W-1:0] mean_ff;
   logic [Q_W-1:0]    rate_ff;
   logic [Q_W-1:0]    reg_ff;
   logic              enable_ff;
   logic              csr_write;
   dp_ctl_type        ctl;
   dp_stat_type       stat;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   // Configuration registers, written in the access phase of an APB write.
   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff   <= MEAN_W'(196608);
         rate_ff   <= Q_W'(328);
         reg_ff    <= Q_W'(1311);
         enable_ff <= 1'b1;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            REG_MEAN:   mean_ff   <= pwdata[MEAN_W-1:0];
            REG_RATE:   rate_ff   <= pwdata[Q_W-1:0];
            REG_REG:    reg_ff    <= pwdata[Q_W-1:0];
            REG_ENABLE: enable_ff <= pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_MEAN:   prdata = 32'(mean_ff);
         REG_RATE:   prdata = 32'(rate_ff);
         REG_REG:    prdata = 32'(reg_ff);
         REG_ENABLE: prdata = 32'(enable_ff);
         default:    prdata = '0;
      endcase
   end

   // The controller decides the step sequence; the datapath holds the tables.
   rbst_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_op         (req_op),
      .req_user_index (req_user_index),
      .req_item_index (req_item_index),
      .update_enable  (enable_ff),
      .stat           (stat),
      .busy           (busy),
      .rsp_strobe     (rsp_strobe),
      .ctl            (ctl)
   );

   rbst_dp u_dp (
      .clock             (clock),
      .ctl               (ctl),
      .stat              (stat),
      .req_user_index    (req_user_index),
      .req_item_index    (req_item_index),
      .req_rating        (req_rating),
      .mean_rating       (mean_ff),
      .learning_rate     (rate_ff),
      .regularization    (reg_ff),
      .rsp_prediction    (rsp_prediction),
      .rsp_error         (rsp_error),
      .rsp_squared_error (rsp_squared_error)
   );

endmodule

// ===== src/rbst_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module rbst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/rbst_ctrl.sv =====
// ----------------------------------------------------------------------------
// Rating bias trainer controller
// Sequences clearing, accumulation, table walks and training steps.
// ----------------------------------------------------------------------------
module rbst_ctrl import rbst_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [2:0]  req_op,
   input  logic [15:0] req_user_index,
   input  logic [13:0] req_item_index,
   input  logic        update_enable,
   input  dp_stat_type stat,
   output logic        busy,
   output logic        rsp_strobe,
   output dp_ctl_type  ctl
);

   typedef enum logic [17:0] {
      ST_CLEAR    = 18'h00001,
      ST_IDLE     = 18'h00002,
      ST_READ     = 18'h00004,
      ST_ACC      = 18'h00008,
      ST_PRED     = 18'h00010,
      ST_SQ       = 18'h00020,
      ST_LOAD_REG = 18'h00040,
      ST_MUL_LO   = 18'h00080,
      ST_MUL_HI   = 18'h00100,
      ST_MUL_FIN  = 18'h00200,
      ST_LOAD_LR  = 18'h00400,
      ST_UPD      = 18'h00800,
      ST_WRITE    = 18'h01000,
      ST_WALK_RD  = 18'h02000,
      ST_WALK_CHK = 18'h04000,
      ST_DIV      = 18'h08000,
      ST_WALK_WR  = 18'h10000,
      ST_RESP     = 18'h20000
   } state_type;

   state_type         state_ff, state_in;
   logic [WALK_W-1:0] walk_ff, walk_in;
   logic [DIVC_W-1:0] div_ff, div_in;
   logic              train_op_ff, train_op_in;
   logic              sel_ff, sel_in;
   logic              phase_ff, phase_in;
   logic              walk_user_ff, walk_user_in;
   logic              train_ff, train_in;
   logic              strobe_ff;
   logic              u_ok, i_ok, walk_last;
   dp_cmd_type        cmd;

   assign u_ok = 32'(req_user_index) < USER_COUNT;
   assign i_ok = 32'(req_item_index) < ITEM_COUNT;
   assign walk_last = walk_user_ff ? (walk_ff == WALK_W'(USER_COUNT - 1))
                                   : (walk_ff == WALK_W'(ITEM_COUNT - 1));

   always_comb begin
      state_in     = state_ff;
      walk_in      = walk_ff;
      div_in       = div_ff;
      train_op_in  = train_op_ff;
      sel_in       = sel_ff;
      phase_in     = phase_ff;
      walk_user_in = walk_user_ff;
      train_in     = train_ff;
      cmd          = CMD_NONE;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd = CMD_CLEAR;
            if (walk_ff == WALK_W'(TABLE_MAX - 1)) begin
               walk_in  = '0;
               state_in = ST_IDLE;
            end else begin
               walk_in = walk_ff + WALK_W'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd         = CMD_LOAD;
               train_in    = 1'b0;
               train_op_in = 1'b0;
               sel_in      = 1'b0;
               walk_in     = '0;
               priority if (req_op == OP_ITEM_ACC && i_ok) begin
                  sel_in   = 1'b1;
                  state_in = ST_READ;
               end else if (req_op == OP_USER_ACC && u_ok && i_ok) begin
                  state_in = ST_READ;
               end else if (req_op == OP_TRAIN && u_ok && i_ok) begin
                  train_op_in = 1'b1;
                  state_in    = ST_READ;
               end else if (req_op == OP_ITEM_FIN) begin
                  walk_user_in = 1'b0;
                  state_in     = ST_WALK_RD;
               end else if (req_op == OP_USER_FIN) begin
                  walk_user_in = 1'b1;
                  state_in     = ST_WALK_RD;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_READ: begin
            cmd      = CMD_READ_REQ;
            state_in = train_op_ff ? ST_PRED : ST_ACC;
         end
         ST_ACC: begin
            cmd      = CMD_ACC;
            state_in = ST_RESP;
         end
         ST_PRED: begin
            cmd      = CMD_PRED;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            cmd      = CMD_SQ;
            train_in = 1'b1;
            state_in = update_enable ? ST_LOAD_REG : ST_RESP;
         end
         ST_LOAD_REG: begin
            cmd      = CMD_LOAD_REG;
            phase_in = 1'b0;
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd      = CMD_MUL_LO;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd      = CMD_MUL_HI;
            state_in = ST_MUL_FIN;
         end
         ST_MUL_FIN: begin
            cmd      = CMD_MUL_FIN;
            state_in = phase_ff ? ST_UPD : ST_LOAD_LR;
         end
         ST_LOAD_LR: begin
            cmd      = CMD_LOAD_LR;
            phase_in = 1'b1;
            state_in = ST_MUL_LO;
         end
         ST_UPD: begin
            cmd = CMD_UPDATE;
            if (!sel_ff) begin
               sel_in   = 1'b1;
               state_in = ST_LOAD_REG;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd      = CMD_WRITE_TRAIN;
            state_in = ST_RESP;
         end
         ST_WALK_RD: begin
            cmd      = CMD_READ_WALK;
            state_in = ST_WALK_CHK;
         end
         ST_WALK_CHK: begin
            cmd      = CMD_WALK_CHECK;
            div_in   = '0;
            state_in = stat.count_zero ? ST_WALK_WR : ST_DIV;
         end
         ST_DIV: begin
            cmd = CMD_DIV_STEP;
            if (div_ff == DIVC_W'(BIAS_W - 1)) begin
               state_in = ST_WALK_WR;
            end else begin
               div_in = div_ff + DIVC_W'(1);
            end
         end
         ST_WALK_WR: begin
            cmd = CMD_WALK_WRITE;
            if (walk_last) begin
               walk_in  = '0;
               state_in = ST_RESP;
            end else begin
               walk_in  = walk_ff + WALK_W'(1);
               state_in = ST_WALK_RD;
            end
         end
         ST_RESP: begin
            cmd      = CMD_RESPOND;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign ctl.cmd       = cmd;
   assign ctl.sel_item  = sel_ff;
   assign ctl.walk_user = walk_user_ff;
   assign ctl.train     = train_ff;
   assign ctl.walk      = walk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         walk_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         walk_ff   <= walk_in;
         strobe_ff <= (state_ff == ST_RESP);
      end
   end

   always_ff @(posedge clock) begin
      div_ff       <= div_in;
      train_op_ff  <= train_op_in;
      sel_ff       <= sel_in;
      phase_ff     <= phase_in;
      walk_user_ff <= walk_user_in;
      train_ff     <= train_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

// ===== src/rbst_dp.sv =====
// ----------------------------------------------------------------------------
// Rating bias trainer datapath
// Bias tables, shared split multiplier, bit-serial divider and result registers.
// ----------------------------------------------------------------------------
module rbst_dp import rbst_pkg::*; (
   input  logic                     clock,
   input  dp_ctl_type               ctl,
   output dp_stat_type              stat,
   input  logic [15:0]              req_user_index,
   input  logic [13:0]              req_item_index,
   input  logic [2:0]               req_rating,
   input  logic [MEAN_W-1:0]        mean_rating,
   input  logic [Q_W-1:0]           learning_rate,
   input  logic [Q_W-1:0]           regularization,
   output logic [PRED_W-1:0]        rsp_prediction,
   output logic signed [ERR_W-1:0]  rsp_error,
   output logic [SQ_W-1:0]          rsp_squared_error
);

   logic [UAW-1:0]            uidx_ff;
   logic [IAW-1:0]            iidx_ff;
   logic [2:0]                rclamp_ff;
   logic [PRED_W-1:0]         pred_ff;
   logic signed [ERR_W-1:0]   err_ff;
   logic [SQ_W-1:0]           sq_ff;
   logic signed [SUM_W-1:0]   mul_a_ff;
   logic [Q_W-1:0]            mul_q_ff;
   logic [MLO_W-1:0]          mlo_ff;
   logic [MHI_W-1:0]          mhi_ff;
   logic signed [SUM_W-1:0]   mres_ff;
   logic signed [BIAS_W-1:0]  nbu_ff, nbi_ff;
   logic [BIAS_W-1:0]         divd_ff;
   logic [DIVS_W-1:0]         divs_ff, rem_ff;
   logic                      neg_ff;
   logic [CNT_W-1:0]          hold_cnt_ff;
   logic [PRED_W-1:0]         rsp_pred_ff;
   logic signed [ERR_W-1:0]   rsp_err_ff;
   logic [SQ_W-1:0]           rsp_sq_ff;

   logic [WORD_W-1:0]         u_rdata, i_rdata, u_wdata, i_wdata, w_word;
   logic                      u_we, i_we, u_re, i_re, walk_addr;
   logic [UAW-1:0]            u_addr;
   logic [IAW-1:0]            i_addr;
   logic signed [BIAS_W-1:0]  bu, bi, w_bias, qv, nb;
   logic [CNT_W-1:0]          cu, ci, w_cnt;
   logic signed [SUM_W-1:0]   rfix, mean_s, acc_item, acc_user, pred_sum, pred_cl;
   logic signed [SUM_W-1:0]   upd_sum;
   logic [ERR_W-1:0]          err_mag;
   logic [2*ERR_W-1:0]        sq_prod, sq_sh;
   logic [SUM_W-1:0]          mul_mag, scaled;
   logic [FULL_W-1:0]         full;
   logic [BIAS_W-1:0]         w_mag;
   logic [DIVS_W:0]           trial;
   logic                      ge;

   assign bu = u_rdata[BIAS_W-1:0];
   assign cu = u_rdata[WORD_W-1:BIAS_W];
   assign bi = i_rdata[BIAS_W-1:0];
   assign ci = i_rdata[WORD_W-1:BIAS_W];

   assign w_word = ctl.walk_user ? u_rdata : i_rdata;
   assign w_bias = w_word[BIAS_W-1:0];
   assign w_cnt  = w_word[WORD_W-1:BIAS_W];
   assign w_mag  = w_bias[BIAS_W-1] ? BIAS_W'(-w_bias) : BIAS_W'(w_bias);
   assign stat.count_zero = (w_cnt == '0);

   assign rfix   = $signed(SUM_W'(rclamp_ff)) <<< FRAC_BITS;
   assign mean_s = $signed(SUM_W'(mean_rating));

   assign acc_item = SUM_W'(bi) + rfix - mean_s;
   assign acc_user = SUM_W'(bu) + rfix - mean_s - SUM_W'(bi);

   // Prediction is clamped to the legal rating range.
   assign pred_sum = mean_s + SUM_W'(bu) + SUM_W'(bi);
   always_comb begin
      priority if (pred_sum < PRED_LO) begin
         pred_cl = PRED_LO;
      end else if (pred_sum > PRED_HI) begin
         pred_cl = PRED_HI;
      end else begin
         pred_cl = pred_sum;
      end
   end

   assign err_mag = err_ff[ERR_W-1] ? ERR_W'(-err_ff) : ERR_W'(err_ff);
   assign sq_prod = (2*ERR_W)'(err_mag) * (2*ERR_W)'(err_mag);
   assign sq_sh   = sq_prod >> FRAC_BITS;

   // The magnitude is multiplied in two halves on one narrow multiplier.
   assign mul_mag = mul_a_ff[SUM_W-1] ? SUM_W'(-mul_a_ff) : SUM_W'(mul_a_ff);
   assign full    = (FULL_W'(mhi_ff) << MUL_SPLIT) + FULL_W'(mlo_ff);
   assign scaled  = SUM_W'(full >> Q_W);

   assign upd_sum = (ctl.sel_item ? SUM_W'(bi) : SUM_W'(bu)) + mres_ff;
   assign nb      = sat_bias(upd_sum);

   assign trial = {rem_ff, divd_ff[BIAS_W-1]};
   assign ge    = (trial >= {1'b0, divs_ff});
   assign qv    = neg_ff ? -$signed(divd_ff) : $signed(divd_ff);

   // Table addressing and write enables.
   assign walk_addr = (ctl.cmd == CMD_CLEAR) || (ctl.cmd == CMD_READ_WALK) ||
                      (ctl.cmd == CMD_WALK_WRITE);
   assign u_addr = walk_addr ? ctl.walk[UAW-1:0] : uidx_ff;
   assign i_addr = walk_addr ? ctl.walk[IAW-1:0] : iidx_ff;

   assign u_re = (ctl.cmd == CMD_READ_REQ) || (ctl.cmd == CMD_READ_WALK && ctl.walk_user);
   assign i_re = (ctl.cmd == CMD_READ_REQ) || (ctl.cmd == CMD_READ_WALK && !ctl.walk_user);
   assign u_we = (ctl.cmd == CMD_CLEAR) || (ctl.cmd == CMD_WRITE_TRAIN) ||
                 (ctl.cmd == CMD_ACC && !ctl.sel_item) ||
                 (ctl.cmd == CMD_WALK_WRITE && ctl.walk_user);
   assign i_we = (ctl.cmd == CMD_CLEAR && 32'(ctl.walk) < ITEM_COUNT) ||
                 (ctl.cmd == CMD_WRITE_TRAIN) ||
                 (ctl.cmd == CMD_ACC && ctl.sel_item) ||
                 (ctl.cmd == CMD_WALK_WRITE && !ctl.walk_user);

   always_comb begin
      unique case (ctl.cmd)
         CMD_ACC: begin
            u_wdata = {cnt_inc(cu), sat_bias(acc_user)};
            i_wdata = {cnt_inc(ci), sat_bias(acc_item)};
         end
         CMD_WRITE_TRAIN: begin
            u_wdata = {cu, nbu_ff};
            i_wdata = {ci, nbi_ff};
         end
         CMD_WALK_WRITE: begin
            u_wdata = {hold_cnt_ff, qv};
            i_wdata = {hold_cnt_ff, qv};
         end
         default: begin
            u_wdata = '0;
            i_wdata = '0;
         end
      endcase
   end

   rbst_ram #(.WIDTH(WORD_W), .DEPTH(USER_COUNT)) u_user_ram (
      .clock (clock),
      .we    (u_we),
      .re    (u_re),
      .addr  (u_addr),
      .wdata (u_wdata),
      .rdata (u_rdata)
   );

   rbst_ram #(.WIDTH(WORD_W), .DEPTH(ITEM_COUNT)) u_item_ram (
      .clock (clock),
      .we    (i_we),
      .re    (i_re),
      .addr  (i_addr),
      .wdata (i_wdata),
      .rdata (i_rdata)
   );

   always_ff @(posedge clock) begin
      unique case (ctl.cmd)
         CMD_LOAD: begin
            uidx_ff <= UAW'(req_user_index);
            iidx_ff <= IAW'(req_item_index);
            priority if (req_rating < RATING_MIN) begin
               rclamp_ff <= RATING_MIN;
            end else if (req_rating > RATING_MAX) begin
               rclamp_ff <= RATING_MAX;
            end else begin
               rclamp_ff <= req_rating;
            end
         end
         CMD_PRED: begin
            pred_ff <= PRED_W'(pred_cl);
            err_ff  <= ERR_W'(rfix - pred_cl);
         end
         CMD_SQ: begin
            sq_ff <= (sq_sh > (2*ERR_W)'(SQ_MAX)) ? SQ_MAX : SQ_W'(sq_sh);
         end
         CMD_LOAD_REG: begin
            mul_a_ff <= ctl.sel_item ? SUM_W'(bi) : SUM_W'(bu);
            mul_q_ff <= regularization;
         end
         CMD_MUL_LO: begin
            mlo_ff <= MLO_W'(mul_mag[MUL_SPLIT-1:0]) * MLO_W'(mul_q_ff);
         end
         CMD_MUL_HI: begin
            mhi_ff <= MHI_W'(mul_mag[SUM_W-1:MUL_SPLIT]) * MHI_W'(mul_q_ff);
         end
         CMD_MUL_FIN: begin
            mres_ff <= mul_a_ff[SUM_W-1] ? -$signed(scaled) : $signed(scaled);
         end
         CMD_LOAD_LR: begin
            mul_a_ff <= SUM_W'(err_ff) - mres_ff;
            mul_q_ff <= learning_rate;
         end
         CMD_UPDATE: begin
            if (ctl.sel_item) begin
               nbi_ff <= nb;
            end else begin
               nbu_ff <= nb;
            end
         end
         CMD_WALK_CHECK: begin
            hold_cnt_ff <= w_cnt;
            neg_ff      <= w_bias[BIAS_W-1];
            divd_ff     <= (w_cnt == '0) ? '0 : w_mag;
            divs_ff     <= DIVS_W'(w_cnt) + (ctl.walk_user ? USER_SHRINK : ITEM_SHRINK);
            rem_ff      <= '0;
         end
         CMD_DIV_STEP: begin
            rem_ff  <= ge ? DIVS_W'(trial - {1'b0, divs_ff}) : trial[DIVS_W-1:0];
            divd_ff <= {divd_ff[BIAS_W-2:0], ge};
         end
         CMD_RESPOND: begin
            rsp_pred_ff <= ctl.train ? pred_ff : '0;
            rsp_err_ff  <= ctl.train ? err_ff : '0;
            rsp_sq_ff   <= ctl.train ? sq_ff : '0;
         end
         default: begin
         end
      endcase
   end

   assign rsp_prediction    = rsp_pred_ff;
   assign rsp_error         = rsp_err_ff;
   assign rsp_squared_error = rsp_sq_ff;

endmodule

// ===== test/rbst_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rating bias trainer checker
// Watches the command, result and register ports, keeps its own bias tables
// and compares every result word with the predicted one.
// ----------------------------------------------------------------------------
module rbst_checker import rbst_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  logic [2:0]              req_op,
   input  logic [15:0]             req_user_index,
   input  logic [13:0]             req_item_index,
   input  logic [2:0]              req_rating,
   input  logic                    rsp_strobe,
   input  logic [PRED_W-1:0]       rsp_prediction,
   input  logic signed [ERR_W-1:0] rsp_error,
   input  logic [SQ_W-1:0]         rsp_squared_error,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [3:0]              paddr,
   input  logic [31:0]             pwdata,
   input  logic                    pready,
   output int                      fail_count,
   output int                      pending
);

   localparam logic [1:0] REG_MEAN = 2'd0;
   localparam logic [1:0] REG_RATE = 2'd1;
   localparam logic [1:0] REG_REG  = 2'd2;
   localparam logic [1:0] REG_ENA  = 2'd3;
   localparam longint     BMAX     = 64'sh7FFF_FFFF_FFFF;
   localparam longint     BMIN     = -BMAX - 1;

   typedef struct {
      logic [PRED_W-1:0]       prediction;
      logic signed [ERR_W-1:0] error;
      logic [SQ_W-1:0]         squared_error;
   } score_type;

   longint          user_sum[int];
   longint          item_sum[int];
   int unsigned     user_cnt[int];
   int unsigned     item_cnt[int];
   logic [18:0]     mean_q;
   logic [15:0]     rate_q;
   logic [15:0]     shrink_q;
   logic            write_back;
   score_type       scores_due[$];

   assign pending = scores_due.size();

   function automatic longint clip_bias(longint v);
      if (v > BMAX) return BMAX;
      if (v < BMIN) return BMIN;
      return v;
   endfunction

   function automatic longint scale_q16(longint a, logic [15:0] q);
      logic [63:0] mag;
      logic [63:0] prod;
      mag  = (a < 0) ? 64'(-a) : 64'(a);
      prod = (mag * 64'(q)) >> 16;
      return (a < 0) ? -longint'(prod) : longint'(prod);
   endfunction

   function automatic longint gradient_step(longint b, longint err);
      return clip_bias(b + scale_q16(err - scale_q16(b, shrink_q), rate_q));
   endfunction

   // Applies one command word to the model tables and returns the score word the block should show.
   function automatic score_type train_score(logic [2:0] op, int u, int i, logic [2:0] rr);
      score_type s;
      longint r, bu, bi, pred, err, mag, sq;
      s = '{0, 0, 0};
      r = (rr < RATING_MIN) ? 1 : (rr > RATING_MAX) ? 5 : longint'(rr);
      r = r << FRAC_BITS;
      if (!item_sum.exists(i)) begin item_sum[i] = 0; item_cnt[i] = 0; end
      if (!user_sum.exists(u)) begin user_sum[u] = 0; user_cnt[u] = 0; end
      case (op)
         OP_ITEM_ACC: begin
            item_sum[i] = clip_bias(item_sum[i] + r - longint'(mean_q));
            if (item_cnt[i] < 32'hFF_FFFF) item_cnt[i]++;
         end
         OP_USER_ACC: begin
            user_sum[u] = clip_bias(user_sum[u] + r - longint'(mean_q) - item_sum[i]);
            if (user_cnt[u] < 32'hFF_FFFF) user_cnt[u]++;
         end
         OP_ITEM_FIN: begin
            foreach (item_sum[k])
               item_sum[k] = (item_cnt[k] == 0) ? 0 : item_sum[k] / (longint'(item_cnt[k]) + 25);
         end
         OP_USER_FIN: begin
            foreach (user_sum[k])
               user_sum[k] = (user_cnt[k] == 0) ? 0 : user_sum[k] / (longint'(user_cnt[k]) + 10);
         end
         OP_TRAIN: begin
            bu   = user_sum[u];
            bi   = item_sum[i];
            pred = longint'(mean_q) + bu + bi;
            if (pred < (64'sd1 << FRAC_BITS)) pred = 64'sd1 << FRAC_BITS;
            if (pred > (64'sd5 << FRAC_BITS)) pred = 64'sd5 << FRAC_BITS;
            err = r - pred;
            mag = (err < 0) ? -err : err;
            sq  = (mag * mag) >>> FRAC_BITS;
            if (sq > 64'h1F_FFFF) sq = 64'h1F_FFFF;
            s.prediction    = PRED_W'(pred);
            s.error         = (err > 524287) ? 20'sh7FFFF :
                              (err < -524288) ? 20'sh80000 : ERR_W'(err);
            s.squared_error = SQ_W'(sq);
            if (write_back) begin
               user_sum[u] = gradient_step(bu, err);
               item_sum[i] = gradient_step(bi, err);
            end
         end
         default: ;
      endcase
      return s;
   endfunction

   always @(posedge clock) begin
      score_type want;
      int        errs;
      errs = 0;
      if (reset) begin
         user_sum.delete();
         item_sum.delete();
         user_cnt.delete();
         item_cnt.delete();
         scores_due.delete();
         mean_q     <= 19'd196608;
         rate_q     <= 16'd328;
         shrink_q   <= 16'd1311;
         write_back <= 1'b1;
         fail_count <= 0;
      end else begin
         if (rsp_strobe) begin
            if (scores_due.size() == 0) begin
               $error("result word with nothing outstanding");
               errs++;
            end else begin
               want = scores_due.pop_front();
               if (rsp_prediction !== want.prediction) begin
                  $error("prediction expected %0d got %0d", want.prediction, rsp_prediction);
                  errs++;
               end
               if (rsp_error !== want.error) begin
                  $error("error expected %0d got %0d", want.error, rsp_error);
                  errs++;
               end
               if (rsp_squared_error !== want.squared_error) begin
                  $error("squared_error expected %0d got %0d",
                         want.squared_error, rsp_squared_error);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         if (start && !busy)
            scores_due.push_back(train_score(req_op, int'(req_user_index),
                                             int'(req_item_index), req_rating));
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_MEAN: mean_q     <= pwdata[18:0];
               REG_RATE: rate_q     <= pwdata[15:0];
               REG_REG:  shrink_q   <= pwdata[15:0];
               REG_ENA:  write_back <= pwdata[0];
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rating bias trainer testbench
// Drives directed and random command words with register changes between
// phases; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top import rbst_pkg::*;;

   // Byte addresses of the four configuration registers.
   localparam logic [3:0] ADDR_MEAN = 4'd0;
   localparam logic [3:0] ADDR_RATE = 4'd4;
   localparam logic [3:0] ADDR_REG  = 4'd8;
   localparam logic [3:0] ADDR_ENA  = 4'd12;
   // Op codes the block does not define; they must give an all-zero word.
   localparam logic [2:0] OP_SPARE_5 = 3'd5;
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;
   localparam int         RANDOM_WORDS = 1330;
   // The limit leaves a wide margin over the clearing pass, the four finalize
   // walks and the training steps.
   localparam int         CYCLE_LIMIT  = 3_000_000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [2:0]              req_op = '0;
   logic [15:0]             req_user_index = '0;
   logic [13:0]             req_item_index = '0;
   logic [2:0]              req_rating = '0;
   logic                    rsp_strobe;
   logic [PRED_W-1:0]       rsp_prediction;
   logic signed [ERR_W-1:0] rsp_error;
   logic [SQ_W-1:0]         rsp_squared_error;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [3:0]              paddr = '0;
   logic [31:0]             pwdata = '0;
   logic [31:0]             prdata;
   logic                    pready;
   int                      fail_count;
   int                      pending;
   int                      cycle_count = 0;
   int                      idle_pct = 12;

   always #4 clock = ~clock;

   rating_bias_sgd_trainer_top u_dut (.*);

   rbst_checker u_checker (.*);

   // Hard stop in case the block hangs with busy high or a word goes missing.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("rating_bias_sgd_trainer_top verification failed");
         $finish;
      end
   end

   // Presents one command word, starting at a rising edge, and returns at the
   // edge that accepts it. Busy is looked at on the falling edge, where it is
   // settled, so acceptance is known before the next rising edge.
   task automatic send_word(logic [2:0] op, logic [15:0] u, logic [13:0] i,
                            logic [2:0] r);
      start          <= 1'b1;
      req_op         <= op;
      req_user_index <= u;
      req_item_index <= i;
      req_rating     <= r;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      // Random sender gaps; start stays high across back-to-back words.
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Registers change only once every outstanding word has come back and the
   // block has had time to settle.
   task automatic write_reg(logic [3:0] addr, logic [31:0] data);
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0 || busy) @(negedge clock);
      repeat (30) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(logic [18:0] mean, logic [15:0] rate, logic [15:0] shrink,
                            logic ena);
      write_reg(ADDR_MEAN, 32'(mean));
      write_reg(ADDR_RATE, 32'(rate));
      write_reg(ADDR_REG, 32'(shrink));
      write_reg(ADDR_ENA, 32'(ena));
   endtask

   initial begin
      logic [2:0]  op;
      logic [15:0] u;
      logic [13:0] i;
      logic [2:0]  r;
      int          pick;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset settings: rating clamping on both
      // ends, the table extremes, the unused op codes, a finalize over an
      // entry that was trained but never accumulated, and both walks.
      send_word(OP_ITEM_ACC, 16'd0, 14'd0, 3'd0);
      send_word(OP_ITEM_ACC, 16'd0, 14'd0, 3'd7);
      send_word(OP_ITEM_ACC, 16'd0, 14'd16383, 3'd5);
      send_word(OP_ITEM_ACC, 16'd0, 14'd16383, 3'd1);
      send_word(OP_ITEM_ACC, 16'd0, 14'd1, 3'd6);
      send_word(OP_TRAIN, 16'd3, 14'd5, 3'd5);
      send_word(OP_SPARE_5, 16'hFFFF, 14'h3FFF, 3'd7);
      send_word(OP_SPARE_6, 16'd1, 14'd1, 3'd3);
      send_word(OP_SPARE_7, 16'd2, 14'd2, 3'd2);
      send_word(OP_ITEM_FIN, 16'd0, 14'd0, 3'd3);
      send_word(OP_USER_ACC, 16'd0, 14'd0, 3'd4);
      send_word(OP_USER_ACC, 16'd65535, 14'd16383, 3'd0);
      send_word(OP_USER_ACC, 16'd65535, 14'd1, 3'd7);
      send_word(OP_USER_ACC, 16'd1, 14'd5, 3'd1);
      send_word(OP_USER_FIN, 16'd0, 14'd0, 3'd1);
      send_word(OP_TRAIN, 16'd0, 14'd0, 3'd1);
      send_word(OP_TRAIN, 16'd65535, 14'd16383, 3'd5);
      send_word(OP_TRAIN, 16'd1, 14'd1, 3'd0);
      send_word(OP_TRAIN, 16'd3, 14'd5, 3'd7);
      send_word(OP_TRAIN, 16'd2, 14'd9, 3'd3);

      // Random part in four register settings, extremes included. Most words
      // train on a small set of users and items so that biases build up.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: configure(19'd65536, 16'd65535, 16'd0, 1'b1);
            1: configure(19'd327680, 16'd0, 16'd65535, 1'b0);
            2: configure(19'd200000, 16'd4000, 16'd30000, 1'b1);
            default: configure(19'd150000, 16'd65535, 16'd65535, 1'b1);
         endcase
         for (int n = 0; n < RANDOM_WORDS / 4; n++) begin
            pick = $urandom_range(99);
            op = (pick < 60) ? OP_TRAIN : (pick < 78) ? OP_ITEM_ACC :
                 (pick < 95) ? OP_USER_ACC : 3'($urandom_range(5, 7));
            // One item finalize in each of the middle phases.
            if (n == 150 && (phase == 1 || phase == 2)) op = OP_ITEM_FIN;
            if ($urandom_range(9) == 0) begin
               u = 16'($urandom);
               i = 14'($urandom);
            end else begin
               u = 16'($urandom_range(15));
               i = 14'($urandom_range(15));
            end
            r = ($urandom_range(99) < 15) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 5));
            // Sender idling: 12 percent, then 50, then none.
            idle_pct = (n < 110) ? 12 : (n < 220) ? 50 : 0;
            send_word(op, u, i, r);
         end
      end
      start <= 1'b0;

      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("rating_bias_sgd_trainer_top verification clean");
      else
         $display("rating_bias_sgd_trainer_top verification failed");
      $finish;
   end

endmodule
